/* hw/rtl/positional_list_engine_unit_macros.svh */
// ----------------------------------------------------------------------------
// Positional list engine assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef POSITIONAL_LIST_ENGINE_UNIT_MACROS_SVH
`define POSITIONAL_LIST_ENGINE_UNIT_MACROS_SVH

// Same-cycle implication.
`define PLE_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define PLE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/ple_pkg.sv */
// ----------------------------------------------------------------------------
// Positional list engine package
// Widths, codes and the command and result types shared by the modules.
// ----------------------------------------------------------------------------
package ple_pkg;

  localparam int CAPACITY = 16;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  localparam int KIND_W  = 2;
  localparam int PLACE_W = 2;
  localparam int POS_W   = 5;
  localparam int VAL_W   = 32;
  localparam int ST_W    = 3;
  localparam int LEN_W   = 5;
  localparam int OP_W    = 4;

  localparam int IN_DATA_W  = 40;
  localparam int IN_USER_W  = KIND_W + PLACE_W;
  localparam int OUT_DATA_W = 40;

  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;

  localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_STREAM = 2'd2;

  localparam logic [PLACE_W-1:0] PLACE_FRONT = 2'd0;
  localparam logic [PLACE_W-1:0] PLACE_AT    = 2'd1;
  localparam logic [PLACE_W-1:0] PLACE_END   = 2'd2;

  localparam logic [ST_W-1:0] ST_OK       = 3'd0;
  localparam logic [ST_W-1:0] ST_BADPOS   = 3'd1;
  localparam logic [ST_W-1:0] ST_EMPTY    = 3'd2;
  localparam logic [ST_W-1:0] ST_FULL     = 3'd3;
  localparam logic [ST_W-1:0] ST_BADPLACE = 3'd4;

  typedef logic [OP_W-1:0] op_t;

  localparam op_t OP_INS_FRONT    = 4'd0;
  localparam op_t OP_INS_AT       = 4'd1;
  localparam op_t OP_INS_END      = 4'd2;
  localparam op_t OP_INS_BADPLACE = 4'd3;
  localparam op_t OP_REM_FRONT    = 4'd4;
  localparam op_t OP_REM_AT       = 4'd5;
  localparam op_t OP_REM_END      = 4'd6;
  localparam op_t OP_REM_BADPLACE = 4'd7;
  localparam op_t OP_STREAM       = 4'd8;
  localparam op_t OP_BADKIND      = 4'd9;

  typedef struct packed {
    op_t                     op;
    logic [POS_W-1:0]        position;
    logic signed [VAL_W-1:0] value;
  } cmd_t;

  typedef struct packed {
    logic [ST_W-1:0]         status;
    logic signed [VAL_W-1:0] element;
    logic [LEN_W-1:0]        length;
    logic                    final_res;
  } res_t;

endpackage

/* hw/rtl/positional_list_engine_unit.sv */
// ----------------------------------------------------------------------------
// Positional list engine
// Ordered list of signed values with positional insert, remove and readout.
// ----------------------------------------------------------------------------
// Each input beat is decoded by the front end and queued for the back end,
// which holds the list in a shifting cell chain. An insert, a remove or a
// rejected beat gives one result beat with the new length. A stream-out
// first starts the sequencer and then gives one result beat per element,
// read through the single read port of the chain, with tlast on the final
// element. Results leave through an output
// register, so the front end keeps taking beats into its two-entry command
// queue while a result waits, and stalls once that queue is full.
module positional_list_engine_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [ple_pkg::IN_DATA_W-1:0]   in_tdata,   // position, value, zero fill
  input  logic [ple_pkg::IN_USER_W-1:0]   in_tuser,   // kind, place
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [ple_pkg::OUT_DATA_W-1:0]  out_tdata,  // status, element, length
  output logic                            out_tlast
);

  logic          q_push, q_ready, b_valid, b_ready;
  ple_pkg::cmd_t q_cmd, b_cmd;
  ple_pkg::res_t res;

  ple_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_push    (q_push),
    .q_ready   (q_ready),
    .q_cmd     (q_cmd)
  );

  ple_cmd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (q_push),
    .push_ready (q_ready),
    .push_cmd   (q_cmd),
    .pop_valid  (b_valid),
    .pop_ready  (b_ready),
    .pop_cmd    (b_cmd)
  );

  ple_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (b_valid),
    .cmd_ready (b_ready),
    .cmd       (b_cmd),
    .res_valid (out_tvalid),
    .res_ready (out_tready),
    .res       (res)
  );

  assign out_tdata = {res.length, res.element, res.status};
  assign out_tlast = res.final_res;

endmodule

/* hw/rtl/ple_front.sv */
// ----------------------------------------------------------------------------
// Positional list engine front end
// Accepts input beats, unpacks them and classifies them into commands.
// ----------------------------------------------------------------------------
module ple_front (
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [ple_pkg::IN_DATA_W-1:0]  in_tdata,  // position, value, zero fill
  input  logic [ple_pkg::IN_USER_W-1:0]  in_tuser,  // kind, place
  output logic                           q_push,
  input  logic                           q_ready,
  output ple_pkg::cmd_t                  q_cmd
);

  logic [ple_pkg::KIND_W-1:0]  kind;
  logic [ple_pkg::PLACE_W-1:0] place;

  assign kind  = in_tuser[ple_pkg::KIND_W-1:0];
  assign place = in_tuser[ple_pkg::KIND_W +: ple_pkg::PLACE_W];

  assign in_tready = q_ready;
  assign q_push    = in_tvalid;

  assign q_cmd.position = in_tdata[ple_pkg::POS_W-1:0];
  assign q_cmd.value    = in_tdata[ple_pkg::POS_W +: ple_pkg::VAL_W];

  always_comb begin
    case (kind)
      ple_pkg::KIND_INSERT: begin
        case (place)
          ple_pkg::PLACE_FRONT: q_cmd.op = ple_pkg::OP_INS_FRONT;
          ple_pkg::PLACE_AT:    q_cmd.op = ple_pkg::OP_INS_AT;
          ple_pkg::PLACE_END:   q_cmd.op = ple_pkg::OP_INS_END;
          default:              q_cmd.op = ple_pkg::OP_INS_BADPLACE;
        endcase
      end
      ple_pkg::KIND_REMOVE: begin
        case (place)
          ple_pkg::PLACE_FRONT: q_cmd.op = ple_pkg::OP_REM_FRONT;
          ple_pkg::PLACE_AT:    q_cmd.op = ple_pkg::OP_REM_AT;
          ple_pkg::PLACE_END:   q_cmd.op = ple_pkg::OP_REM_END;
          default:              q_cmd.op = ple_pkg::OP_REM_BADPLACE;
        endcase
      end
      ple_pkg::KIND_STREAM: q_cmd.op = ple_pkg::OP_STREAM;
      default:              q_cmd.op = ple_pkg::OP_BADKIND;
    endcase
  end

endmodule

/* hw/rtl/ple_cmd_queue.sv */
// ----------------------------------------------------------------------------
// Positional list engine command queue
// Short FIFO of classified commands between the front and the back end.
// ----------------------------------------------------------------------------
module ple_cmd_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push_valid,
  output logic          push_ready,
  input  ple_pkg::cmd_t push_cmd,
  output logic          pop_valid,
  input  logic          pop_ready,
  output ple_pkg::cmd_t pop_cmd
);

  ple_pkg::cmd_t              mem_r [ple_pkg::Q_DEPTH];
  logic [ple_pkg::Q_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [ple_pkg::Q_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [ple_pkg::Q_PTR_W:0]   fill_r, fill_nxt;
  logic                        do_push, do_pop;

  assign push_ready = (fill_r != (ple_pkg::Q_PTR_W+1)'(ple_pkg::Q_DEPTH));
  assign pop_valid  = (fill_r != '0);
  assign pop_cmd    = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    fill_nxt   = fill_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == ple_pkg::Q_PTR_W'(ple_pkg::Q_DEPTH - 1)) ? '0
                                                                          : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == ple_pkg::Q_PTR_W'(ple_pkg::Q_DEPTH - 1)) ? '0
                                                                          : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      fill_nxt = fill_r + 1'b1;
    end else if (do_pop && !do_push) begin
      fill_nxt = fill_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

/* hw/rtl/ple_back.sv */
// ----------------------------------------------------------------------------
// Positional list engine back end
// Shifting cell chain, range checks, stream sequencer and output register.
// ----------------------------------------------------------------------------
module ple_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cmd_valid,
  output logic          cmd_ready,
  input  ple_pkg::cmd_t cmd,
  output logic          res_valid,
  input  logic          res_ready,
  output ple_pkg::res_t res
);

  logic signed [ple_pkg::VAL_W-1:0] cells_r   [ple_pkg::CAPACITY];
  logic signed [ple_pkg::VAL_W-1:0] cells_nxt [ple_pkg::CAPACITY];
  logic [ple_pkg::LEN_W-1:0]        count_r, count_nxt;
  logic                             busy_r, busy_nxt;
  logic [ple_pkg::IDX_W-1:0]        sidx_r, sidx_nxt;
  logic                             out_valid_r, out_valid_nxt;
  ple_pkg::res_t                    res_r, res_nxt;

  logic                             free, full, empty, ins_pos_ok, rem_pos_ok;
  logic                             do_ins, do_rem, load, stream_last;
  logic [ple_pkg::LEN_W-1:0]        ins_slot, rem_slot;
  logic [ple_pkg::ST_W-1:0]         status;

  assign free      = !out_valid_r || res_ready;
  assign cmd_ready = free && !busy_r;
  assign res_valid = out_valid_r;
  assign res       = res_r;

  assign full  = (count_r >= ple_pkg::LEN_W'(ple_pkg::CAPACITY));
  assign empty = (count_r == '0);
  assign ins_pos_ok = (cmd.position != '0) && (cmd.position <= count_r + 1'b1);
  assign rem_pos_ok = (cmd.position != '0) && (cmd.position <= count_r);
  assign stream_last = ((ple_pkg::LEN_W'(sidx_r) + 1'b1) == count_r);

  always_comb begin
    case (cmd.op)
      ple_pkg::OP_INS_FRONT: ins_slot = '0;
      ple_pkg::OP_INS_END:   ins_slot = count_r;
      default:               ins_slot = cmd.position - 1'b1;
    endcase
    case (cmd.op)
      ple_pkg::OP_REM_FRONT: rem_slot = '0;
      ple_pkg::OP_REM_END:   rem_slot = count_r - 1'b1;
      default:               rem_slot = cmd.position - 1'b1;
    endcase
  end

  always_comb begin
    do_ins   = 1'b0;
    do_rem   = 1'b0;
    load     = 1'b0;
    status   = ple_pkg::ST_OK;
    busy_nxt = busy_r;
    sidx_nxt = sidx_r;
    if (free) begin
      if (busy_r) begin
        load = 1'b1;
        if (stream_last) begin
          busy_nxt = 1'b0;
        end else begin
          sidx_nxt = sidx_r + 1'b1;
        end
      end else if (cmd_valid) begin
        case (cmd.op)
          ple_pkg::OP_INS_FRONT, ple_pkg::OP_INS_AT, ple_pkg::OP_INS_END: begin
            load = 1'b1;
            if (full) begin
              status = ple_pkg::ST_FULL;
            end else if ((cmd.op == ple_pkg::OP_INS_AT) && !ins_pos_ok) begin
              status = ple_pkg::ST_BADPOS;
            end else begin
              do_ins = 1'b1;
            end
          end
          ple_pkg::OP_REM_FRONT, ple_pkg::OP_REM_AT, ple_pkg::OP_REM_END: begin
            load = 1'b1;
            if (empty) begin
              status = ple_pkg::ST_EMPTY;
            end else if ((cmd.op == ple_pkg::OP_REM_AT) && !rem_pos_ok) begin
              status = ple_pkg::ST_BADPOS;
            end else begin
              do_rem = 1'b1;
            end
          end
          ple_pkg::OP_REM_BADPLACE: begin
            load   = 1'b1;
            status = empty ? ple_pkg::ST_EMPTY : ple_pkg::ST_BADPLACE;
          end
          ple_pkg::OP_STREAM: begin
            if (empty) begin
              load   = 1'b1;
              status = ple_pkg::ST_EMPTY;
            end else begin
              busy_nxt = 1'b1;
              sidx_nxt = '0;
            end
          end
          default: begin
            load   = 1'b1;
            status = ple_pkg::ST_BADPLACE;
          end
        endcase
      end
    end
  end

  always_comb begin
    count_nxt = count_r;
    for (int i = 0; i < ple_pkg::CAPACITY; i++) begin
      cells_nxt[i] = cells_r[i];
      if (do_ins) begin
        if (ple_pkg::LEN_W'(i) > ins_slot) begin
          cells_nxt[i] = cells_r[(i == 0) ? 0 : i - 1];
        end else if (ple_pkg::LEN_W'(i) == ins_slot) begin
          cells_nxt[i] = cmd.value;
        end
      end else if (do_rem) begin
        if ((ple_pkg::LEN_W'(i) >= rem_slot) && (i < ple_pkg::CAPACITY - 1)) begin
          cells_nxt[i] = cells_r[(i == ple_pkg::CAPACITY - 1) ? i : i + 1];
        end
      end
    end
    if (do_ins) begin
      count_nxt = count_r + 1'b1;
    end else if (do_rem) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    res_nxt       = res_r;
    if (free) begin
      out_valid_nxt = load;
    end
    if (load) begin
      res_nxt.status    = status;
      res_nxt.element   = busy_r ? cells_r[sidx_r] : '0;
      res_nxt.length    = count_nxt;
      res_nxt.final_res = busy_r ? stream_last : 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      busy_r      <= 1'b0;
      sidx_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      busy_r      <= busy_nxt;
      sidx_r      <= sidx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
    for (int i = 0; i < ple_pkg::CAPACITY; i++) begin
      cells_r[i] <= cells_nxt[i];
    end
  end

endmodule

/* hw/rtl/ple_checker.sv */
// ----------------------------------------------------------------------------
// Positional list engine port checker
// Watches the top-level ports for stream rules of this block.
// ----------------------------------------------------------------------------
`include "positional_list_engine_unit_macros.svh"

module ple_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic [ple_pkg::IN_DATA_W-1:0]   in_tdata,
  input logic [ple_pkg::IN_USER_W-1:0]   in_tuser,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [ple_pkg::OUT_DATA_W-1:0]  out_tdata,
  input logic                            out_tlast
);

  logic [ple_pkg::ST_W-1:0]  st;
  logic [ple_pkg::VAL_W-1:0] elem;
  logic [ple_pkg::LEN_W-1:0] len;

  assign st   = out_tdata[ple_pkg::ST_W-1:0];
  assign elem = out_tdata[ple_pkg::ST_W +: ple_pkg::VAL_W];
  assign len  = out_tdata[ple_pkg::ST_W + ple_pkg::VAL_W +: ple_pkg::LEN_W];

  `PLE_ASSERT_NEXT(a_in_hold, in_tvalid && !in_tready, in_tvalid && $stable(in_tdata) && $stable(in_tuser), "stalled input beat changed")
  `PLE_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tlast), "stalled result beat changed")
  `PLE_ASSERT_IMPL(a_err_last, out_tvalid && (st != ple_pkg::ST_OK), out_tlast, "error beat without tlast")
  `PLE_ASSERT_IMPL(a_err_elem, out_tvalid && (st != ple_pkg::ST_OK), elem == '0, "error beat with nonzero element")
  `PLE_ASSERT_IMPL(a_len_cap, out_tvalid, len <= ple_pkg::LEN_W'(ple_pkg::CAPACITY), "length beyond capacity")

endmodule

bind positional_list_engine_unit ple_checker u_ple_checker (.*);
